// File: hw/rtl/tws_pkg.sv
package tws_pkg;

    // Default table geometry.
    localparam int DEF_TABLE_ENTRIES = 256;
    localparam int DEF_BUCKET_WAYS   = 4;

    // Timestamp scaling, and the multiplier digit of the constant dividers
    // (dividend bits taken per cycle).
    localparam int STAMP_DIVISOR = 10000000;
    localparam int DIV_STEP      = 16;

    localparam int ADDR_W  = 32;
    localparam int PORT_W  = 16;
    localparam int SCALE_W = 8;
    localparam int STAMP_W = 48;
    localparam int RTT_W   = 25;
    localparam int KEY_W   = ADDR_W + PORT_W;

    // Result status codes.
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_SRC_MISS = 2'd1;
    localparam logic [1:0] ST_DST_MISS = 2'd2;

    // Input word.
    typedef struct packed {
        logic               is_tcp;
        logic [ADDR_W-1:0]  src_addr;
        logic [ADDR_W-1:0]  dst_addr;
        logic [PORT_W-1:0]  src_port_num;
        logic [PORT_W-1:0]  dst_port_num;
        logic               syn_bit;
        logic               ack_bit;
        logic               fin_bit;
        logic               rst_bit;
        logic [SCALE_W-1:0] scale_option;
        logic [STAMP_W-1:0] stamp;
    } item_t;

    // Result word.
    typedef struct packed {
        logic [ADDR_W-1:0]  out_src_addr;
        logic [ADDR_W-1:0]  out_dst_addr;
        logic [PORT_W-1:0]  out_src_port;
        logic [PORT_W-1:0]  out_dst_port;
        logic [RTT_W-1:0]   rtt_units;
        logic [SCALE_W-1:0] src_scale;
        logic [SCALE_W-1:0] dst_scale;
        logic [1:0]         status;
    } result_t;

    // One way of a table bucket.
    typedef struct packed {
        logic               valid;
        logic [KEY_W-1:0]   key;
        logic [SCALE_W-1:0] scale;
    } way_t;

    // What an accepted word asks of the table.
    typedef enum logic [1:0] {
        K_NOP    = 2'd0,
        K_INSERT = 2'd1,
        K_LOOKUP = 2'd2
    } kind_t;

    // Controller to datapath commands.
    typedef struct packed {
        logic load;
        logic clr_write;
        logic rd_src;
        logic rd_dst;
        logic cap_src;
        logic cap_dst;
        logic ins_write;
    } cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        kind_t kind;
        logic  calc_done;
        logic  clr_last;
    } stat_t;

endpackage

// File: hw/rtl/tws_cdiv.sv
module tws_cdiv
    import tws_pkg::*;
#(
    parameter int WIDTH   = 32,
    parameter int DIVISOR = 64,
    parameter int STEP    = DIV_STEP
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [WIDTH-1:0]                 dividend,
    output logic                             busy,
    output logic [WIDTH-1:0]                 quotient,
    output logic [$clog2(DIVISOR+1)-1:0]     remainder
);

    localparam int STEPS = (WIDTH + STEP - 1) / STEP;
    localparam int PADW  = STEPS * STEP;
    localparam int RW    = $clog2(DIVISOR + 1);
    localparam int LG    = $clog2(DIVISOR);
    localparam int SH    = WIDTH + LG;
    localparam int MW    = WIDTH + 2;
    localparam int PW    = SH + 2;
    localparam int AW    = PADW + MW;
    localparam int CW    = $clog2(STEPS + 2);

    // Reciprocal ceil(2^SH / DIVISOR); exact quotients for every WIDTH-bit dividend.
    localparam logic [PW-1:0] POW        = PW'(1) << SH;
    localparam logic [PW-1:0] RECIP_FULL = (POW + PW'(DIVISOR) - PW'(1)) / PW'(DIVISOR);
    localparam logic [MW-1:0] RECIP      = RECIP_FULL[MW-1:0];
    localparam logic [RW-1:0] DVSR       = RW'(DIVISOR);

    logic [PADW-1:0]  num_reg, num_next;
    logic [AW-1:0]    acc_reg, acc_next;
    logic [RW-1:0]    low_reg, low_next;
    logic [WIDTH-1:0] quo_reg, quo_next;
    logic [RW-1:0]    rem_reg, rem_next;
    logic [CW-1:0]    cnt_reg, cnt_next;

    // Multiply by the reciprocal, STEP dividend bits per cycle, most significant first; a last cycle
    // takes the quotient from the product and the remainder as the dividend's low bits less quotient times divisor.
    always_comb
    begin
        logic [STEP-1:0]    chunk;
        logic [MW+STEP-1:0] prod;
        logic [RW-1:0]      qd;
        chunk = num_reg[PADW-1 -: STEP];
        prod  = RECIP * chunk;
        qd    = RW'(acc_reg >> SH) * DVSR;
        num_next = num_reg;
        acc_next = acc_reg;
        low_next = low_reg;
        quo_next = quo_reg;
        rem_next = rem_reg;
        cnt_next = cnt_reg;
        if (start)
        begin
            num_next = PADW'(dividend);
            acc_next = '0;
            low_next = RW'(dividend);
            cnt_next = CW'(STEPS + 1);
        end
        else if (cnt_reg > CW'(1))
        begin
            num_next = num_reg << STEP;
            acc_next = (acc_reg << STEP) + AW'(prod);
            cnt_next = cnt_reg - 1'b1;
        end
        else if (cnt_reg == CW'(1))
        begin
            quo_next = WIDTH'(acc_reg >> SH);
            rem_next = low_reg - qd;
            cnt_next = '0;
        end
    end

    // The counter is control state; the operands need no reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        acc_reg <= acc_next;
        low_reg <= low_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign busy      = (cnt_reg != '0);
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// File: hw/rtl/tws_datapath.sv
module tws_datapath
    import tws_pkg::*;
#(
    parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES,
    parameter int BUCKET_WAYS   = DEF_BUCKET_WAYS
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  item_t   item,
    input  cmd_t    cmd,
    output stat_t   stat,
    output result_t result
);

    localparam int SET_COUNT = (TABLE_ENTRIES / BUCKET_WAYS > 0) ?
                               (TABLE_ENTRIES / BUCKET_WAYS) : 1;
    localparam int USED_WAYS = (BUCKET_WAYS < TABLE_ENTRIES) ? BUCKET_WAYS : TABLE_ENTRIES;
    localparam int SW        = (SET_COUNT > 1) ? $clog2(SET_COUNT) : 1;
    localparam int HRW       = $clog2(SET_COUNT + 1);

    item_t               item_reg;
    kind_t               item_kind;
    logic [SW-1:0]       clr_cnt_reg, clr_cnt_next;
    logic                src_found_reg, dst_found_reg;
    logic [SCALE_W-1:0]  src_scale_reg, dst_scale_reg;

    logic                src_busy, dst_busy, stamp_busy;
    logic [ADDR_W-1:0]   src_q_unused, dst_q_unused;
    logic [HRW-1:0]      src_rem, dst_rem;
    logic [STAMP_W-1:0]  stamp_quo;
    logic [$clog2(STAMP_DIVISOR+1)-1:0] stamp_rem;

    way_t [USED_WAYS-1:0] bucket_mem_reg [SET_COUNT];
    way_t [USED_WAYS-1:0] rdata_reg;
    way_t [USED_WAYS-1:0] wrow;
    logic                 mem_we, mem_re;
    logic [SW-1:0]        mem_addr;

    logic [KEY_W-1:0]     src_key, dst_key, look_key;
    logic                 hit;
    logic [SCALE_W-1:0]   hit_scale;
    logic [USED_WAYS-1:0] free_oh;
    logic                 any_free;

    // Classify the word on the input port.
    always_comb
    begin
        item_kind = K_NOP;
        if (item.is_tcp)
        begin
            if (item.syn_bit)
            begin
                item_kind = K_INSERT;
            end
            else if (item.ack_bit && !item.fin_bit && !item.rst_bit)
            begin
                item_kind = K_LOOKUP;
            end
        end
    end

    // Hold the accepted word.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= item;
        end
    end

    // Set numbers of both endpoints and the scaled timestamp.
    tws_cdiv #(.WIDTH(ADDR_W), .DIVISOR(SET_COUNT)) u_src_hash (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.load),
        .dividend  (item.src_addr ^ {{(ADDR_W-PORT_W){1'b0}}, item.src_port_num}),
        .busy      (src_busy),
        .quotient  (src_q_unused),
        .remainder (src_rem)
    );

    tws_cdiv #(.WIDTH(ADDR_W), .DIVISOR(SET_COUNT)) u_dst_hash (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.load),
        .dividend  (item.dst_addr ^ {{(ADDR_W-PORT_W){1'b0}}, item.dst_port_num}),
        .busy      (dst_busy),
        .quotient  (dst_q_unused),
        .remainder (dst_rem)
    );

    tws_cdiv #(.WIDTH(STAMP_W), .DIVISOR(STAMP_DIVISOR)) u_stamp_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.load),
        .dividend  (item.stamp),
        .busy      (stamp_busy),
        .quotient  (stamp_quo),
        .remainder (stamp_rem)
    );

    // Clearing sweep over the bucket rows after reset.
    assign clr_cnt_next  = cmd.clr_write ? clr_cnt_reg + 1'b1 : clr_cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else
        begin
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    // Status to the controller.
    assign stat = '{kind:      item_kind,
                    calc_done: !src_busy && !dst_busy && !stamp_busy,
                    clr_last:  (clr_cnt_reg == SW'(SET_COUNT - 1))};

    assign src_key  = {item_reg.src_addr, item_reg.src_port_num};
    assign dst_key  = {item_reg.dst_addr, item_reg.dst_port_num};
    assign look_key = cmd.cap_dst ? dst_key : src_key;

    // Compare the key against every way of the row just read; first hit wins.
    always_comb
    begin
        hit       = 1'b0;
        hit_scale = '0;
        for (int w = 0; w < USED_WAYS; w++)
        begin
            if (!hit && rdata_reg[w].valid && (rdata_reg[w].key == look_key))
            begin
                hit       = 1'b1;
                hit_scale = rdata_reg[w].scale;
            end
        end
    end

    // Lowest free way of the row.
    always_comb
    begin
        any_free = 1'b0;
        free_oh  = '0;
        for (int w = 0; w < USED_WAYS; w++)
        begin
            if (!any_free && !rdata_reg[w].valid)
            begin
                any_free   = 1'b1;
                free_oh[w] = 1'b1;
            end
        end
    end

    // Row to write: cleared on the sweep, otherwise the read row plus the new way.
    always_comb
    begin
        wrow = rdata_reg;
        for (int w = 0; w < USED_WAYS; w++)
        begin
            if (free_oh[w])
            begin
                wrow[w].valid = 1'b1;
                wrow[w].key   = src_key;
                wrow[w].scale = item_reg.scale_option;
            end
        end
        if (cmd.clr_write)
        begin
            wrow = '0;
        end
    end

    assign mem_we = cmd.clr_write || (cmd.ins_write && !hit && any_free);
    assign mem_re = cmd.rd_src || cmd.rd_dst;

    always_comb
    begin
        mem_addr = clr_cnt_reg;
        if (cmd.rd_src || cmd.ins_write)
        begin
            mem_addr = src_rem[SW-1:0];
        end
        else if (cmd.rd_dst)
        begin
            mem_addr = dst_rem[SW-1:0];
        end
    end

    // Single-port bucket memory with registered read data.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            bucket_mem_reg[mem_addr] <= wrow;
        end
        if (mem_re)
        begin
            rdata_reg <= bucket_mem_reg[mem_addr];
        end
    end

    // Capture the lookups of both endpoints; a missing scale reads zero.
    always_ff @(posedge clk)
    begin
        if (cmd.cap_src)
        begin
            src_found_reg <= hit;
            src_scale_reg <= hit_scale;
        end
        if (cmd.cap_dst)
        begin
            dst_found_reg <= hit;
            dst_scale_reg <= hit_scale;
        end
    end

    // Result word.
    always_comb
    begin
        result.out_src_addr = item_reg.src_addr;
        result.out_dst_addr = item_reg.dst_addr;
        result.out_src_port = item_reg.src_port_num;
        result.out_dst_port = item_reg.dst_port_num;
        result.rtt_units    = stamp_quo[RTT_W-1:0];
        result.src_scale    = src_scale_reg;
        result.dst_scale    = dst_scale_reg;
        if (!src_found_reg)
        begin
            result.status = ST_SRC_MISS;
        end
        else if (!dst_found_reg)
        begin
            result.status = ST_DST_MISS;
        end
        else
        begin
            result.status = ST_OK;
        end
    end

endmodule

// File: hw/rtl/tws_ctrl.sv
module tws_ctrl
    import tws_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    input  stat_t stat,
    output cmd_t  cmd,
    output logic  busy,
    output logic  done
);

    typedef enum logic [6:0] {
        S_CLEAR   = 7'b0000001,
        S_IDLE    = 7'b0000010,
        S_WAIT    = 7'b0000100,
        S_RD_SRC  = 7'b0001000,
        S_CHK_SRC = 7'b0010000,
        S_CHK_DST = 7'b0100000,
        S_EMIT    = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    kind_t  kind_reg, kind_next;

    // Reset sweep, then per word: hashing, bucket reads, insert or result.
    always_comb
    begin
        state_next = state_reg;
        kind_next  = kind_reg;
        cmd        = '0;
        done       = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_write = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load  = 1'b1;
                    kind_next = stat.kind;
                    if (stat.kind != K_NOP)
                    begin
                        state_next = S_WAIT;
                    end
                end
            end
            S_WAIT:
            begin
                if (stat.calc_done)
                begin
                    state_next = S_RD_SRC;
                end
            end
            S_RD_SRC:
            begin
                cmd.rd_src = 1'b1;
                state_next = S_CHK_SRC;
            end
            S_CHK_SRC:
            begin
                if (kind_reg == K_INSERT)
                begin
                    cmd.ins_write = 1'b1;
                    state_next    = S_IDLE;
                end
                else
                begin
                    cmd.cap_src = 1'b1;
                    cmd.rd_dst  = 1'b1;
                    state_next  = S_CHK_DST;
                end
            end
            S_CHK_DST:
            begin
                cmd.cap_dst = 1'b1;
                state_next  = S_EMIT;
            end
            S_EMIT:
            begin
                done       = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            kind_reg  <= K_NOP;
        end
        else
        begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule

// File: hw/rtl/tcp_window_scale_tracker.sv
// A word that needs no table work (not TCP, FIN or RST without SYN, no flag) is taken while the
// block stays idle. Other words wait for the reciprocal dividers (16 bits a cycle) and then read the
// single-port bucket memory: a SYN reads its source row and on a miss fills a free way, with no result
// strobe; an ACK reads the source row, then the destination row, and strobes done. No new word is taken
// until the last one is through; results cannot be stalled. After reset the bucket rows (TABLE_ENTRIES /
// BUCKET_WAYS, 64 by default) are cleared one per cycle, and busy stays high until the sweep ends.
module tcp_window_scale_tracker
    import tws_pkg::*;
#(
    parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES,
    parameter int BUCKET_WAYS   = DEF_BUCKET_WAYS
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    output logic    busy,
    input  item_t   item,
    output logic    done,
    output result_t result
);

    cmd_t  cmd;
    stat_t stat;

    tws_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    tws_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .BUCKET_WAYS   (BUCKET_WAYS)
    ) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .cmd    (cmd),
        .stat   (stat),
        .result (result)
    );

endmodule

// File: hw/rtl/tws_checker.sv
module tws_checker
    import tws_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    start,
    input logic    busy,
    input item_t   item,
    input logic    done,
    input result_t result
);

    // A result is only shown while a word is in progress.
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n) done |-> busy)
        else $error("result strobe while idle");

    // The block is ready again right after a result.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n) done |=> !busy && !done)
        else $error("block not idle after result");

    // No result can follow an accepted word in the very next cycle.
    a_no_early: assert property (@(posedge clk) disable iff (!rst_n) (start && !busy) |=> !done)
        else $error("result too early after accept");

    // The status is one of the defined codes.
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.status == ST_OK || result.status == ST_SRC_MISS ||
                  result.status == ST_DST_MISS))
        else $error("undefined status code");

    // A missing source scale reads zero.
    a_src_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status == ST_SRC_MISS) |-> (result.src_scale == '0))
        else $error("missing source scale not zero");

endmodule

bind tcp_window_scale_tracker tws_checker u_checker (.*);
